// ===== sv/frame_period_late_detector_core_assert.svh =====
// ----------------------------------------------------------------------------
// Frame period late detector assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_PERIOD_LATE_DETECTOR_CORE_ASSERT_SVH
`define FRAME_PERIOD_LATE_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checks an implication or plain property on every rising clock edge.
`define FPLD_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("fpld assertion failed");
// Checks that an expression never holds.
`define FPLD_ASSERT_NEVER(lbl, clk_i, rst_ni, expr) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
		else $error("fpld forbidden condition seen");
`else
`define FPLD_ASSERT(lbl, clk_i, rst_ni, prop)
`define FPLD_ASSERT_NEVER(lbl, clk_i, rst_ni, expr)
`endif

`endif

// ===== sv/fpld_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame period late detector package
// Item types, sequencer states, register indexes and divider status.
// ----------------------------------------------------------------------------
package fpld_pkg;

	localparam int unsigned TS_W       = 48;
	localparam int unsigned PERIOD_W   = 32;
	localparam int unsigned INTERVAL_W = 40;
	localparam int unsigned LATE_W     = 16;
	localparam int unsigned FILL_OUT_W = 6;

	// Configuration register indexes.
	localparam logic REG_TRACK_LATE      = 1'b0;
	localparam logic REG_REPORT_INTERVAL = 1'b1;

	// Input opcodes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 40'd1000000000;

	typedef struct packed {
		logic            opcode;
		logic [TS_W-1:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]   frame_period;
		logic [PERIOD_W-1:0]   mean_period;
		logic                  is_late;
		logic                  report_due;
		logic [LATE_W-1:0]     late_total;
		logic [TS_W-1:0]       elapsed;
		logic [FILL_OUT_W-1:0] window_fill;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_JUDGE,
		ST_UPDATE,
		ST_REPORT,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== sv/fpld_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpld_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/fpld_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces a 32-bit floor quotient of the window sum by the fill count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpld_div #(
	parameter int unsigned SUM_W = 38,
	parameter int unsigned DIV_W = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SUM_W-1:0]          dividend,
	input  logic [DIV_W-1:0]          divisor,
	output fpld_pkg::div_status_t     status,
	output logic [fpld_pkg::PERIOD_W-1:0] quotient
);

	localparam int unsigned QW = fpld_pkg::PERIOD_W;
	localparam int unsigned CW = $clog2(QW);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] divisor_q;
	logic [QW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	// The caller guarantees dividend < divisor * 2^32, so the upper part
	// already sits below the divisor and 32 steps give the whole quotient.
	assign trial = {rem_q, quo_q[QW-1]} - {1'b0, divisor_q};
	assign fits  = ({rem_q, quo_q[QW-1]} >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= dividend[SUM_W-1:QW];
			quo_q     <= dividend[QW-1:0];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], quo_q[QW-1]};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// ===== sv/frame_period_late_detector_core.sv =====
// ----------------------------------------------------------------------------
// Frame period late detector core
// Measures frame periods, flags late frames against a sliding-window mean
// and raises periodic report events.
// ----------------------------------------------------------------------------
// A start item goes straight from acceptance to the output register. A frame
// mark, when the window holds periods, takes the period, runs the serial
// divider that forms the window mean, then judges lateness, updates the
// window, evaluates the report interval and loads the output register. With
// an empty window the divider is skipped. The input is stalled while an item
// is in work; a finished item waits in the output register and the next
// input item is accepted while it does. The period store is a RAM of WINDOW
// entries with no reset; only entries that were written are ever read.
// ----------------------------------------------------------------------------
`include "frame_period_late_detector_core_assert.svh"

module frame_period_late_detector_core #(
	parameter int unsigned WINDOW = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input items.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fpld_pkg::in_item_t    in_item,
	// Result items.
	output logic                  out_valid,
	input  logic                  out_stall,
	output fpld_pkg::out_item_t   out_item,
	// Configuration writes.
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [fpld_pkg::INTERVAL_W-1:0] cfg_wdata
);

	localparam int unsigned TS_W  = fpld_pkg::TS_W;
	localparam int unsigned PW    = fpld_pkg::PERIOD_W;
	localparam int unsigned IW    = $clog2(WINDOW);
	localparam int unsigned FW    = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W = PW + FW;
	localparam int unsigned HALF  = WINDOW / 2;

	fpld_pkg::state_t state_q, state_d;

	// Configuration.
	logic                            track_q;
	logic [fpld_pkg::INTERVAL_W-1:0] interval_q;

	// Window state.
	logic [IW-1:0]    oldest_q;
	logic [FW-1:0]    fill_q;
	logic [SUM_W-1:0] sum_q;

	// Time stamps and counters.
	logic [TS_W-1:0]              start_time_q;
	logic [TS_W-1:0]              last_frame_q;
	logic [TS_W-1:0]              last_report_q;
	logic [fpld_pkg::LATE_W-1:0]  late_count_q;

	// Per-item working values.
	logic [TS_W-1:0]             now_q;
	logic [PW-1:0]               period_q;
	logic [PW-1:0]               mean_q;
	logic                        late_q;
	logic                        due_q;
	logic [fpld_pkg::LATE_W-1:0] total_q;
	logic [TS_W-1:0]             elapsed_q;

	// Output register.
	logic                 out_valid_q;
	fpld_pkg::out_item_t  out_item_q;

	logic in_accept;
	logic is_frame;
	logic out_free;
	logic div_start;
	logic ram_we;

	fpld_pkg::div_status_t div_st;
	logic [PW-1:0]         quotient;

	logic [TS_W-1:0] frame_diff;
	logic [PW-1:0]   period_sat;
	logic [PW-1:0]   mean_sel;
	logic [PW+1:0]   mean_x3;
	logic [PW+1:0]   period_x2;
	logic [FW:0]     fill_plus1;
	logic            late_now;
	logic [IW:0]     pos_sum;
	logic [IW-1:0]   pos;
	logic [IW-1:0]   ram_waddr;
	logic [PW-1:0]   ram_rdata;
	logic            window_full;
	logic [TS_W-1:0] report_diff;
	logic            due_now;
	logic [FW+fpld_pkg::FILL_OUT_W-1:0] fill_ext;

	assign in_accept = in_valid && !in_stall;
	assign is_frame  = (in_item.opcode == fpld_pkg::OP_FRAME);
	assign out_free  = !out_valid_q || !out_stall;

	// Period since the previous frame, saturated to 32 bits.
	assign frame_diff = in_item.timestamp - last_frame_q;
	assign period_sat = (frame_diff[TS_W-1:PW] != '0) ? {PW{1'b1}} : frame_diff[PW-1:0];

	// Late test: period * 2 >= mean * 3, only with a window at least half full.
	assign mean_sel   = (fill_q == '0) ? period_q : quotient;
	assign mean_x3    = {2'b00, mean_sel} + {1'b0, mean_sel, 1'b0};
	assign period_x2  = {1'b0, period_q, 1'b0};
	assign fill_plus1 = {1'b0, fill_q} + 1'b1;
	assign late_now   = track_q && (fill_plus1 >= (FW + 1)'(HALF)) && (period_x2 >= mean_x3);

	// Ring position of the next free slot while the window is still filling.
	assign window_full = (fill_q == FW'(WINDOW));
	assign pos_sum     = {1'b0, oldest_q} + {1'b0, fill_q[IW-1:0]};
	assign pos         = (pos_sum >= (IW + 1)'(WINDOW)) ?
	                     IW'(pos_sum - (IW + 1)'(WINDOW)) : pos_sum[IW-1:0];
	assign ram_waddr   = window_full ? oldest_q : pos;

	assign report_diff = now_q - last_report_q;
	assign due_now     = (report_diff >= {{(TS_W - fpld_pkg::INTERVAL_W){1'b0}}, interval_q});

	assign fill_ext = {{fpld_pkg::FILL_OUT_W{1'b0}}, fill_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpld_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (!is_frame) begin
						state_d = fpld_pkg::ST_OUTPUT;
					end else if (fill_q == '0) begin
						state_d = fpld_pkg::ST_JUDGE;
					end else begin
						state_d = fpld_pkg::ST_DIV;
					end
				end
			end
			fpld_pkg::ST_DIV: begin
				if (div_st.done) begin
					state_d = fpld_pkg::ST_JUDGE;
				end
			end
			fpld_pkg::ST_JUDGE:  state_d = fpld_pkg::ST_UPDATE;
			fpld_pkg::ST_UPDATE: state_d = fpld_pkg::ST_REPORT;
			fpld_pkg::ST_REPORT: state_d = fpld_pkg::ST_OUTPUT;
			fpld_pkg::ST_OUTPUT: begin
				if (out_free) begin
					state_d = fpld_pkg::ST_IDLE;
				end
			end
			default: state_d = fpld_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			fpld_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && is_frame && (fill_q != '0);
			end
			fpld_pkg::ST_UPDATE: ram_we = !late_q;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control state, window bookkeeping and time stamps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fpld_pkg::ST_IDLE;
			track_q       <= 1'b1;
			interval_q    <= fpld_pkg::INTERVAL_RESET;
			oldest_q      <= '0;
			fill_q        <= '0;
			sum_q         <= '0;
			start_time_q  <= '0;
			last_frame_q  <= '0;
			last_report_q <= '0;
			late_count_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					fpld_pkg::REG_TRACK_LATE:      track_q    <= cfg_wdata[0];
					fpld_pkg::REG_REPORT_INTERVAL: interval_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (state_q == fpld_pkg::ST_IDLE && in_accept) begin
				last_frame_q <= in_item.timestamp;
				if (!is_frame) begin
					start_time_q  <= in_item.timestamp;
					last_report_q <= in_item.timestamp;
				end
			end

			// A late frame only bumps the counter; others enter the window,
			// displacing the oldest period once the window is full.
			if (state_q == fpld_pkg::ST_UPDATE) begin
				if (late_q) begin
					if (late_count_q != {fpld_pkg::LATE_W{1'b1}}) begin
						late_count_q <= late_count_q + 1'b1;
					end
				end else if (!window_full) begin
					sum_q  <= sum_q + SUM_W'(period_q);
					fill_q <= fill_q + 1'b1;
				end else begin
					sum_q    <= sum_q - SUM_W'(ram_rdata) + SUM_W'(period_q);
					oldest_q <= (oldest_q == IW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
				end
			end

			if (state_q == fpld_pkg::ST_REPORT && due_now) begin
				last_report_q <= now_q;
				if (track_q) begin
					late_count_q <= '0;
				end
			end

			if (state_q == fpld_pkg::ST_OUTPUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-item working values and the output payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fpld_pkg::ST_IDLE: begin
				if (in_accept) begin
					now_q     <= in_item.timestamp;
					period_q  <= is_frame ? period_sat : '0;
					mean_q    <= '0;
					late_q    <= 1'b0;
					due_q     <= 1'b0;
					total_q   <= '0;
					elapsed_q <= '0;
				end
			end
			fpld_pkg::ST_JUDGE: begin
				mean_q <= mean_sel;
				late_q <= late_now;
			end
			fpld_pkg::ST_UPDATE: begin
				elapsed_q <= now_q - start_time_q;
			end
			fpld_pkg::ST_REPORT: begin
				due_q   <= due_now;
				total_q <= (due_now && track_q) ? late_count_q : '0;
			end
			fpld_pkg::ST_OUTPUT: begin
				if (out_free) begin
					out_item_q.frame_period <= period_q;
					out_item_q.mean_period  <= mean_q;
					out_item_q.is_late      <= late_q;
					out_item_q.report_due   <= due_q;
					out_item_q.late_total   <= total_q;
					out_item_q.elapsed      <= elapsed_q;
					out_item_q.window_fill  <= fill_ext[fpld_pkg::FILL_OUT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Mean of the window: sum over fill count, one quotient bit a cycle.
	fpld_div #(
		.SUM_W(SUM_W),
		.DIV_W(FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.status   (div_st),
		.quotient (quotient)
	);

	// Period ring. The read address is the oldest slot, which holds still
	// from acceptance to the update, so the registered read is ready in time.
	fpld_ram #(
		.WIDTH(PW),
		.DEPTH(WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (period_q),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	// A late frame leaves the window fill untouched.
	`FPLD_ASSERT(a_late_keeps_fill, clk, arst_n,
		(state_q == fpld_pkg::ST_UPDATE && late_q) |=> $stable(fill_q))
	// An empty window carries no sum.
	`FPLD_ASSERT(a_empty_sum_zero, clk, arst_n, (fill_q == '0) |-> (sum_q == '0))
	// The divider only finishes while the sequencer waits for it.
	`FPLD_ASSERT(a_div_done_in_div, clk, arst_n, div_st.done |-> (state_q == fpld_pkg::ST_DIV))
	// The window never holds more than its depth.
	`FPLD_ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > FW'(WINDOW))

endmodule

// ===== dv/tb_frame_period_late_detector_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame period late detector core testbench
// Drives start and frame mark items through the core with random idling and
// output stalls. A local model of the period window, the late judgment and
// the report timer predicts every result item, and a monitor compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_frame_period_late_detector_core;

	import fpld_pkg::*;

	localparam int unsigned WIN = 60;
	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;
	localparam int unsigned RANDOM_ITEMS = 500;

	// Clock, reset and all inputs of the core start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [INTERVAL_W-1:0] cfg_wdata = '0;

	// Items waiting to be offered, and results predicted but not yet seen.
	in_item_t item_backlog[$];
	out_item_t awaited_results[$];

	// Idling percentages of the current phase.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned error_count = 0;

	// Local copy of the core state: the period window, the time stamps,
	// the late tally and both configuration registers.
	logic [PERIOD_W-1:0] win_ring[WIN];
	int unsigned win_oldest;
	int unsigned win_fill;
	logic [63:0] win_sum;
	logic [TS_W-1:0] t_start;
	logic [TS_W-1:0] t_last_frame;
	logic [TS_W-1:0] t_last_report;
	int unsigned late_tally;
	logic cfg_track;
	logic [INTERVAL_W-1:0] cfg_interval;

	// Time stamp of the stimulus stream, advanced by each generated period.
	logic [TS_W-1:0] stim_clock;

	frame_period_late_detector_core #(
		.WINDOW(WIN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result item of one accepted input item and advances the
	// local state. A start only moves the three time stamps; the window and
	// the late tally survive it.
	function automatic out_item_t compute_frame_result(in_item_t it);
		out_item_t r;
		logic [TS_W-1:0] gap;
		logic [TS_W-1:0] since_report;
		logic [63:0] period;
		logic [63:0] mean;
		int unsigned pos;
		r = '0;
		if (it.opcode == OP_START) begin
			t_start = it.timestamp;
			t_last_frame = it.timestamp;
			t_last_report = it.timestamp;
		end else begin
			// Differences wrap modulo the 48-bit counter; the period saturates.
			gap = it.timestamp - t_last_frame;
			period = (gap > 48'hFFFF_FFFF) ? 64'hFFFF_FFFF : {16'b0, gap};
			t_last_frame = it.timestamp;
			// An empty window compares the period with itself.
			mean = (win_fill != 0) ? win_sum / win_fill : period;
			// The late judgment needs tracking on and a window at least half
			// full, counting the frame at hand.
			if (cfg_track && (win_fill + 1 >= WIN / 2) && (period * 2 >= mean * 3)) begin
				r.is_late = 1'b1;
				if (late_tally < 16'hFFFF)
					late_tally++;
			end else if (win_fill < WIN) begin
				pos = (win_oldest + win_fill) % WIN;
				win_ring[pos] = period[PERIOD_W-1:0];
				win_sum += period;
				win_fill++;
			end else begin
				// A full window drops its oldest period for the new one.
				pos = win_oldest;
				win_sum -= {32'b0, win_ring[pos]};
				win_ring[pos] = period[PERIOD_W-1:0];
				win_sum += period;
				win_oldest = (pos + 1) % WIN;
			end
			since_report = it.timestamp - t_last_report;
			if ({16'b0, since_report} >= {24'b0, cfg_interval}) begin
				r.report_due = 1'b1;
				// With tracking off the tally is neither handed out nor cleared.
				if (cfg_track) begin
					r.late_total = late_tally[LATE_W-1:0];
					late_tally = 0;
				end
				t_last_report = it.timestamp;
			end
			r.frame_period = period[PERIOD_W-1:0];
			r.mean_period = mean[PERIOD_W-1:0];
			r.elapsed = t_last_frame - t_start;
		end
		r.window_fill = win_fill[FILL_OUT_W-1:0];
		return r;
	endfunction

	// Driver: offers the next item from the backlog unless the sender idles.
	// A stalled item is held unchanged, and an accepted one goes straight
	// into the model.
	always @(posedge clk) begin
		logic fire;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire)
				awaited_results.insert(awaited_results.size(), compute_frame_result(in_item));
			if (!in_valid || fire) begin
				if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_item <= item_backlog[0];
					item_backlog.delete(0);
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Monitor: every accepted result must match the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none expected, actual %0h", $time, out_item);
					error_count++;
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					check_field("frame_period", 64'(want.frame_period),
						64'(out_item.frame_period));
					check_field("mean_period", 64'(want.mean_period),
						64'(out_item.mean_period));
					check_field("is_late", 64'(want.is_late), 64'(out_item.is_late));
					check_field("report_due", 64'(want.report_due),
						64'(out_item.report_due));
					check_field("late_total", 64'(want.late_total),
						64'(out_item.late_total));
					check_field("elapsed", 64'(want.elapsed), 64'(out_item.elapsed));
					check_field("window_fill", 64'(want.window_fill),
						64'(out_item.window_fill));
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic queue_item(logic op, logic [TS_W-1:0] ts);
		in_item_t it;
		it.opcode = op;
		it.timestamp = ts;
		item_backlog.insert(item_backlog.size(), it);
	endtask

	// Waits until the backlog is offered, the last item accepted and its
	// result seen. Sampling on the falling edge keeps this free of races
	// with the driver and the monitor. Every item yields a result, so the
	// core is idle then, and the wait that follows covers the output register.
	task automatic wait_all_results();
		while (item_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register while the core is idle and mirrors it in the model.
	task automatic set_register(logic idx, logic [INTERVAL_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TRACK_LATE)
			cfg_track = val[0];
		else
			cfg_interval = val;
	endtask

	// Sets the idling of both sides: none, sender only, receiver only, both.
	task automatic set_idling(int unsigned mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 70;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 70;
			end
			default: begin
				send_idle_pct = 29;
				stall_pct = 29;
			end
		endcase
	endtask

	// Run-time limit, many times the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned base;
		int unsigned jit;
		int unsigned len;
		int unsigned pick;
		logic [63:0] step;
		logic [63:0] prod;
		logic [TS_W-1:0] rnd_ts;

		// The model comes up in the reset state of the core.
		foreach (win_ring[i])
			win_ring[i] = '0;
		win_oldest = 0;
		win_fill = 0;
		win_sum = '0;
		t_start = '0;
		t_last_frame = '0;
		t_last_report = '0;
		late_tally = 0;
		cfg_track = 1'b1;
		cfg_interval = INTERVAL_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed items under the reset configuration. The first frames come
		// before any start, so they measure from the reset time stamps. Then
		// a zero period, a saturated gap, and a start just below the wrap.
		set_idling(0);
		queue_item(OP_FRAME, 48'd5);
		queue_item(OP_FRAME, 48'd5);
		queue_item(OP_FRAME, 48'hFFFF_FFFF_FFFF);
		queue_item(OP_START, 48'hFFFF_FFFF_FFFD);
		queue_item(OP_FRAME, 48'd2);
		queue_item(OP_START, 48'd0);
		queue_item(OP_FRAME, 48'd0);
		wait_all_results();

		// A zero interval reports at every frame; with tracking off the
		// tally is kept. Gaps of exactly 2^32 and 2^32-1 sit on either side
		// of saturation.
		set_register(REG_REPORT_INTERVAL, '0);
		set_register(REG_TRACK_LATE, 40'd0);
		set_idling(3);
		queue_item(OP_FRAME, 48'd100);
		queue_item(OP_FRAME, 48'd300);
		queue_item(OP_FRAME, 48'd300 + 48'h1_0000_0000);
		queue_item(OP_FRAME, 48'd300 + 48'h1_0000_0000 + 48'hFFFF_FFFF);
		wait_all_results();

		// The largest interval elapses only on the long wrapped gap; alternating bit patterns
		// and a wrap through zero exercise every timestamp bit.
		set_register(REG_REPORT_INTERVAL, INTERVAL_MAX);
		set_register(REG_TRACK_LATE, 40'd1);
		set_idling(1);
		queue_item(OP_START, 48'hAAAA_AAAA_AAAA);
		queue_item(OP_FRAME, 48'hAAAA_AAAA_AAB1);
		queue_item(OP_FRAME, 48'h5555_5555_5555);
		queue_item(OP_START, 48'hFFFF_FFFF_FFFF);
		queue_item(OP_FRAME, 48'd0);
		wait_all_results();

		// The smallest nonzero interval: a zero gap does not report.
		set_register(REG_REPORT_INTERVAL, 40'd1);
		set_idling(2);
		queue_item(OP_FRAME, 48'd1);
		queue_item(OP_FRAME, 48'd1);
		queue_item(OP_FRAME, 48'd4);
		wait_all_results();

		// Random part: each phase is one start followed by a run of frames
		// with a steady base period, so the window fills far enough for late
		// judgments and wraps for evictions. Late spikes, near-threshold
		// periods, saturated gaps, zero periods, restarts and random noise
		// are mixed in.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_all_results();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				base = $urandom_range(1, 20);
			else if (pick == 1)
				base = $urandom_range(32'h4000_0000, 32'h8000_0000);
			else
				base = $urandom_range(50, 5000);

			set_register(REG_TRACK_LATE, 40'($urandom_range(0, 3) != 0));
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				set_register(REG_REPORT_INTERVAL, '0);
			end else if (pick == 1) begin
				set_register(REG_REPORT_INTERVAL, 40'd1);
			end else if (pick == 2) begin
				set_register(REG_REPORT_INTERVAL, INTERVAL_MAX);
			end else if (pick == 3) begin
				prod = {$urandom(), $urandom()};
				set_register(REG_REPORT_INTERVAL, prod[INTERVAL_W-1:0]);
			end else begin
				prod = 64'(base) * $urandom_range(1, 25);
				set_register(REG_REPORT_INTERVAL, prod[INTERVAL_W-1:0]);
			end
			set_idling(phase);

			// Some runs start just below the wrap of the counter.
			if ($urandom_range(0, 3) == 0)
				stim_clock = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100000));
			else
				stim_clock = 48'({$urandom(), $urandom()});
			queue_item(OP_START, stim_clock);
			random_items++;

			len = $urandom_range(30, 90);
			jit = base / 8;
			for (int unsigned k = 0; k < len; k++) begin
				// Now and then the sender holds off until every result is in.
				if (k == len / 2 && phase % 3 == 0)
					wait_all_results();
				pick = $urandom_range(0, 99);
				if (pick < 78) begin
					step = 64'(base - jit) + $urandom_range(0, 2 * jit);
				end else if (pick < 88) begin
					step = 64'(base) * 2 + $urandom_range(0, base);
				end else if (pick < 91) begin
					step = (64'(base) * 3) / 2 - $urandom_range(0, 1);
				end else if (pick < 93) begin
					step = 64'h1_0000_0000 + $urandom();
				end else begin
					step = '0;
				end
				if (pick >= 95 && pick < 97) begin
					queue_item(OP_START, stim_clock);
				end else if (pick >= 97) begin
					rnd_ts = 48'({$urandom(), $urandom()});
					queue_item(1'($urandom_range(0, 1)), rnd_ts);
					stim_clock = rnd_ts;
				end else begin
					stim_clock = stim_clock + step[TS_W-1:0];
					queue_item(OP_FRAME, stim_clock);
				end
				random_items++;
			end
			phase++;
		end

		// Drain, then give the core time to show any stray result.
		wait_all_results();
		repeat (100) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
